FILE: rtl/tga_sd_pkg.sv
// Shared types, status codes and pixel helpers for the TGA stream decoder.
// No dependencies; the parser, outbuf, checker, top unit and testbench import it.
`default_nettype none
package tga_sd_pkg;

  localparam int PaletteDepthDefault = 256;
  localparam int HeaderLen           = 18;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FORMAT   = 3'd1;
  localparam logic [2:0] ST_NO_CMAP  = 3'd2;
  localparam logic [2:0] ST_BAD_IDX  = 3'd3;
  localparam logic [2:0] ST_TRUNC    = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic [7:0]  run_length;
    logic [31:0] first_pixel;
    logic        top_origin;
    logic        frame_done;
    logic [2:0]  status;
    logic        use_pal;
  } res_t;

  // Reorders stored BGR(A) bytes to RGB(A); two-byte pixels become 5-bit channels.
  function automatic logic [31:0] unpack(input logic [31:0] w, input logic [5:0] nb);
    logic [7:0] b0, b1, b2, b3;
    b0 = w[7:0];
    b1 = w[15:8];
    b2 = w[23:16];
    b3 = w[31:24];
    if (nb == 6'd4) return {b3, b0, b1, b2};
    else if (nb == 6'd3) return {8'h00, b0, b1, b2};
    else return {8'h00, 3'b000, b0[4:0], 3'b000, b1[1:0], b0[7:5], 3'b000, b1[6:2]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tga_sd_if.sv
// Stream interfaces for the TGA stream decoder: byte input and result output.
// Depends on tga_sd_pkg for nothing but keeps field widths consistent with it.
`default_nettype none
interface tga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface tga_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        has_alpha;
  logic [7:0]  run_length;
  logic [31:0] first_pixel;
  logic        top_origin;
  logic        frame_done;
  logic [2:0]  status;
  modport source (output valid, red, green, blue, alpha, has_alpha, run_length,
                  first_pixel, top_origin, frame_done, status, input ready);
  modport sink   (input valid, red, green, blue, alpha, has_alpha, run_length,
                  first_pixel, top_origin, frame_done, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/tga_stream_decoder_unit.sv
// TGA stream decoder: one file byte per cycle in while ready, colour runs out.
// Throughput: one byte per cycle while the skid word is empty; a result is
// registered, and indexed colours come from the registered palette read.
// A stalled result is parked in a skid word so one more byte can still enter.
// Synchronous reset clears the parser and output control; the palette keeps
// its contents and needs no clearing pass.
`default_nettype none
module tga_stream_decoder_unit
  import tga_sd_pkg::*;
#(
  parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tga_in_if.sink      in_ch,
  tga_out_if.source   out_ch
);

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic              acc, produce, in_ready, out_valid;
  logic              wr_en, rd_en;
  logic [PAL_AW-1:0] wr_addr, rd_addr;
  logic [31:0]       wr_data, rd_data;
  res_t              res, out_res;

  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  tga_sd_parser #(.PALETTE_DEPTH(PALETTE_DEPTH), .PAL_AW(PAL_AW)) u_parser (
    .clk(clk), .rst(rst), .acc(acc),
    .data_byte(in_ch.data_byte), .stream_end(in_ch.stream_end),
    .produce(produce), .res(res),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr)
  );

  tga_sd_palette #(.PALETTE_DEPTH(PALETTE_DEPTH), .PAL_AW(PAL_AW)) u_palette (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  tga_sd_outbuf u_outbuf (
    .clk(clk), .rst(rst), .produce(produce), .res(res), .rd_data(rd_data),
    .out_ready(out_ch.ready), .in_ready(in_ready),
    .out_valid(out_valid), .out_res(out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.red         = out_res.red;
  assign out_ch.green       = out_res.green;
  assign out_ch.blue        = out_res.blue;
  assign out_ch.alpha       = out_res.alpha;
  assign out_ch.has_alpha   = out_res.has_alpha;
  assign out_ch.run_length  = out_res.run_length;
  assign out_ch.first_pixel = out_res.first_pixel;
  assign out_ch.top_origin  = out_res.top_origin;
  assign out_ch.frame_done  = out_res.frame_done;
  assign out_ch.status      = out_res.status;

endmodule
`default_nettype wire

FILE: rtl/tga_sd_palette.sv
// Colour-map memory: one write port, one read port with registered data.
// Depends on nothing beyond its parameters.
`default_nettype none
module tga_sd_palette #(
  parameter int PALETTE_DEPTH = 256,
  parameter int PAL_AW = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [PAL_AW-1:0] wr_addr,
  input  wire logic [31:0]       wr_data,
  input  wire logic              rd_en,
  input  wire logic [PAL_AW-1:0] rd_addr,
  output logic      [31:0]       rd_data
);

  logic [31:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: rtl/tga_sd_parser.sv
// Byte parser: header capture, skips, colour-map load and packet decoding.
// Depends on tga_sd_pkg; drives the palette ports and hands results downstream.
`default_nettype none
module tga_sd_parser
  import tga_sd_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int PAL_AW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              acc,
  input  wire logic [7:0]        data_byte,
  input  wire logic              stream_end,
  output logic                   produce,
  output res_t                   res,
  output logic                   wr_en,
  output logic [PAL_AW-1:0]      wr_addr,
  output logic [31:0]            wr_data,
  output logic                   rd_en,
  output logic [PAL_AW-1:0]      rd_addr
);

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_ID_SKIP   = 3'd1;
  localparam logic [2:0] PH_CMAP_SKIP = 3'd2;
  localparam logic [2:0] PH_CMAP_LOAD = 3'd3;
  localparam logic [2:0] PH_PKT_HEAD  = 3'd4;
  localparam logic [2:0] PH_PIXEL     = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [23:0] bc, bc_next;
  logic [63:0] hdr0, hdr0_next;
  logic [47:0] hdr1, hdr1_next;
  logic [31:0] asmw, asmw_next;
  logic [7:0]  pleft, pleft_next;
  logic        is_run, is_run_next;
  logic [31:0] pc, pc_next;
  logic [31:0] ptotal, ptotal_next;

  logic [7:0]  ityp, cmap_type, ebits, pbits, desc;
  logic [15:0] cfirst, clen, iw, ih;
  logic [5:0]  ent_b, pix_b;
  logic [31:0] product, slot, remain;
  logic [23:0] skip_len;
  logic [2:0]  chk;
  logic        ha, emit, use_pal, do_after, do_enter, done, wr, bad;
  logic [2:0]  h1_idx;
  logic [7:0]  cnt, run;
  logic [15:0] idx;
  logic [31:0] col, asm_cur;
  res_t        r;

  // Header fields are taken from the view that already holds the current byte.
  always_comb begin
    ityp      = hdr0_next[23:16];
    cmap_type = hdr0_next[15:8];
    cfirst    = hdr0_next[39:24];
    clen      = hdr0_next[55:40];
    ebits     = hdr0_next[63:56];
    iw        = hdr1_next[15:0];
    ih        = hdr1_next[31:16];
    pbits     = hdr1_next[39:32];
    desc      = hdr1_next[47:40];
    ent_b     = 6'(({1'b0, ebits} + 9'd7) >> 3);
    pix_b     = 6'(({1'b0, pbits} + 9'd7) >> 3);
    product   = iw * ih;
    skip_len  = 24'({8'h00, clen} * {18'h0, ent_b});
    ha        = ityp[0] ? (ent_b == 6'd4) : (pix_b == 6'd4);
    if ((ityp & 8'hF4) != 8'h00 || ityp[1:0] == 2'b11 || ityp[1:0] == 2'b00) chk = ST_FORMAT;
    else if (ityp[0] && cmap_type == 8'h00) chk = ST_NO_CMAP;
    else if (ityp[0] && (pix_b < 6'd1 || pix_b > 6'd2 || ent_b < 6'd2 || ent_b > 6'd4))
      chk = ST_FORMAT;
    else if (!ityp[0] && (pix_b < 6'd2 || pix_b > 6'd4)) chk = ST_FORMAT;
    else chk = ST_OK;
  end

  always_comb begin
    hdr0_next   = hdr0;
    hdr1_next   = hdr1;
    h1_idx      = 3'(bc[4:0] - 5'd12);
    if (phase == PH_HEADER) begin
      if (bc < 24'd8) hdr0_next[{bc[2:0], 3'b000} +: 8] = data_byte;
      else if (bc >= 24'd12 && bc < 24'(HeaderLen)) hdr1_next[{h1_idx, 3'b000} +: 8] = data_byte;
    end
  end

  always_comb begin
    phase_next  = phase;
    bc_next     = bc;
    asmw_next   = asmw;
    pleft_next  = pleft;
    is_run_next = is_run;
    pc_next     = pc;
    ptotal_next = ptotal;
    emit        = 1'b0;
    use_pal     = 1'b0;
    do_after    = 1'b0;
    do_enter    = 1'b0;
    wr          = 1'b0;
    done        = 1'b0;
    bad         = 1'b0;
    cnt         = {1'b0, data_byte[6:0]} + 8'd1;
    remain      = ptotal - pc;
    slot        = {16'h0000, cfirst} + pc;
    asm_cur     = asmw | ({24'h0, data_byte} << {bc[1:0], 3'b000});
    idx         = 16'h0000;
    col         = 32'h0;
    run         = 8'd1;
    r           = '0;
    r.has_alpha  = ha;
    r.top_origin = desc[5];
    r.first_pixel = pc;

    unique case (phase)
      PH_HEADER: begin
        bc_next = bc + 24'd1;
        if (bc_next >= 24'(HeaderLen)) begin
          bc_next = 24'd0;
          if (chk != ST_OK) begin
            phase_next = PH_DONE;
            emit = 1'b1;
            r.frame_done = 1'b1;
            r.status = chk;
          end else begin
            ptotal_next = product;
            if (hdr0_next[7:0] != 8'h00) begin
              phase_next = PH_ID_SKIP;
              bc_next = {16'h0000, hdr0_next[7:0]};
            end else begin
              do_after = 1'b1;
            end
          end
        end
      end
      PH_ID_SKIP: begin
        bc_next = bc - 24'd1;
        if (bc_next == 24'd0) do_after = 1'b1;
      end
      PH_CMAP_SKIP: begin
        bc_next = bc - 24'd1;
        if (bc_next == 24'd0) do_enter = 1'b1;
      end
      PH_CMAP_LOAD: begin
        asmw_next = asm_cur;
        bc_next = bc + 24'd1;
        if (bc_next >= {18'h0, ent_b}) begin
          wr = slot < 32'(PALETTE_DEPTH);
          pc_next = pc + 32'd1;
          bc_next = 24'd0;
          asmw_next = 32'h0;
          if (pc_next >= {16'h0000, clen}) do_enter = 1'b1;
        end
      end
      PH_PKT_HEAD: begin
        if ({24'h0, cnt} > remain) begin
          phase_next = PH_DONE;
          emit = 1'b1;
          r.frame_done = 1'b1;
          r.status = ST_OVERFLOW;
        end else begin
          pleft_next = cnt;
          is_run_next = data_byte[7];
          bc_next = 24'd0;
          asmw_next = 32'h0;
          phase_next = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        asmw_next = asm_cur;
        bc_next = bc + 24'd1;
        if (bc_next >= {18'h0, pix_b}) begin
          idx = asmw_next[15:0];
          if (ityp[0]) begin
            bad = idx < cfirst || (idx - cfirst) >= clen ||
                  {16'h0000, idx} >= 32'(PALETTE_DEPTH);
            use_pal = 1'b1;
          end else begin
            col = unpack(asmw_next, pix_b);
          end
          emit = 1'b1;
          if (bad) begin
            use_pal = 1'b0;
            phase_next = PH_DONE;
            r.frame_done = 1'b1;
            r.status = ST_BAD_IDX;
          end else begin
            run = (ityp[3] && is_run) ? pleft : 8'd1;
            pc_next = pc + {24'h0, run};
            done = pc_next == ptotal;
            bc_next = 24'd0;
            asmw_next = 32'h0;
            if (ityp[3]) begin
              pleft_next = is_run ? 8'd0 : pleft - 8'd1;
              if (pleft_next == 8'd0) phase_next = PH_PKT_HEAD;
            end
            if (done) phase_next = PH_DONE;
            r.red = col[7:0];
            r.green = col[15:8];
            r.blue = col[23:16];
            r.alpha = ha ? col[31:24] : 8'h00;
            r.run_length = run;
            r.frame_done = done;
            r.use_pal = use_pal;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (do_after) begin
      if (cmap_type != 8'h00 && ityp[0] && clen != 16'h0000) begin
        phase_next = PH_CMAP_LOAD;
        bc_next = 24'd0;
        pc_next = 32'd0;
        asmw_next = 32'h0;
      end else if (cmap_type != 8'h00 && !ityp[0] && skip_len != 24'd0) begin
        phase_next = PH_CMAP_SKIP;
        bc_next = skip_len;
      end else begin
        do_enter = 1'b1;
      end
    end

    if (do_enter) begin
      pc_next = 32'd0;
      bc_next = 24'd0;
      asmw_next = 32'h0;
      pleft_next = 8'd0;
      is_run_next = 1'b0;
      if (ptotal_next == 32'd0) begin
        phase_next = PH_DONE;
        emit = 1'b1;
        r.first_pixel = 32'd0;
        r.frame_done = 1'b1;
        r.status = ST_OK;
      end else begin
        phase_next = ityp[3] ? PH_PKT_HEAD : PH_PIXEL;
      end
    end

    if (stream_end) begin
      if (phase_next != PH_DONE) begin
        if (emit) begin
          r.frame_done = 1'b1;
          r.status = ST_TRUNC;
        end else begin
          emit = 1'b1;
          r.first_pixel = pc_next;
          r.frame_done = 1'b1;
          r.status = ST_TRUNC;
        end
      end
      phase_next  = PH_HEADER;
      bc_next     = 24'd0;
      asmw_next   = 32'h0;
      pleft_next  = 8'd0;
      is_run_next = 1'b0;
      pc_next     = 32'd0;
      ptotal_next = 32'd0;
    end
  end

  assign produce = acc && emit;
  assign res     = r;
  assign wr_en   = acc && wr;
  assign wr_addr = slot[PAL_AW-1:0];
  assign wr_data = unpack(asm_cur, ent_b);
  assign rd_en   = acc && emit && r.use_pal;
  assign rd_addr = idx[PAL_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      bc     <= 24'd0;
      hdr0   <= 64'h0;
      hdr1   <= 48'h0;
      asmw   <= 32'h0;
      pleft  <= 8'd0;
      is_run <= 1'b0;
      pc     <= 32'd0;
      ptotal <= 32'd0;
    end else if (acc) begin
      phase  <= phase_next;
      bc     <= bc_next;
      hdr0   <= stream_end ? 64'h0 : hdr0_next;
      hdr1   <= stream_end ? 48'h0 : hdr1_next;
      asmw   <= asmw_next;
      pleft  <= pleft_next;
      is_run <= is_run_next;
      pc     <= pc_next;
      ptotal <= ptotal_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tga_sd_outbuf.sv
// Result register plus skid word; merges palette read data into indexed pixels.
// Depends on tga_sd_pkg for the result record.
`default_nettype none
module tga_sd_outbuf
  import tga_sd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        produce,
  input  wire res_t        res,
  input  wire logic [31:0] rd_data,
  input  wire logic        out_ready,
  output logic             in_ready,
  output logic             out_valid,
  output res_t             out_res
);

  res_t main_r, skid_r, main_res;
  logic main_valid, skid_valid, take;

  // The read data serves the main word; a new read moves a waiting one to the skid.
  always_comb begin
    main_res = main_r;
    if (main_r.use_pal) begin
      main_res.red   = rd_data[7:0];
      main_res.green = rd_data[15:8];
      main_res.blue  = rd_data[23:16];
      main_res.alpha = main_r.has_alpha ? rd_data[31:24] : 8'h00;
    end
    main_res.use_pal = 1'b0;
  end

  assign in_ready  = !skid_valid;
  assign out_valid = skid_valid || main_valid;
  assign out_res   = skid_valid ? skid_r : main_res;
  assign take      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (produce) begin
      if (main_valid && !take) begin
        skid_r     <= main_res;
        skid_valid <= 1'b1;
      end
      main_r     <= res;
      main_valid <= 1'b1;
    end else if (take) begin
      main_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/tga_sd_checker.sv
// Port-level checks for the TGA stream decoder and the bind that attaches them.
// Depends on tga_sd_pkg for status codes.
`default_nettype none
module tga_sd_checker
  import tga_sd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  run_length,
  input wire logic        frame_done,
  input wire logic [2:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_run_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> run_length <= 8'd128)
    else $error("run length above one packet");

  a_err_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> frame_done)
    else $error("error status without frame end");

  a_err_norun: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK && status != ST_TRUNC |-> run_length == 8'd0)
    else $error("format error carries pixels");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OVERFLOW)
    else $error("status code out of range");

endmodule

bind tga_stream_decoder_unit tga_sd_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .run_length(out_ch.run_length), .frame_done(out_ch.frame_done),
  .status(out_ch.status)
);
`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for tga_stream_decoder_unit: builds TGA files, streams them
// in byte by byte and checks every colour run against a decoder model kept here.
// Depends on tga_sd_pkg and the tga_in_if / tga_out_if interfaces.
module tb_top;
  import tga_sd_pkg::*;

  localparam int PalDepth = PaletteDepthDefault;
  localparam longint CycleLimit = 3000000;

  typedef enum int {PH_HDR, PH_ID, PH_CMAP_SKIP, PH_CMAP_LOAD, PH_PKT, PH_PIX, PH_DONE} dec_phase_t;
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

  typedef struct {
    logic [7:0]  red, green, blue, alpha;
    logic        has_alpha;
    logic [7:0]  run_length;
    logic [31:0] first_pixel;
    logic        top_origin, frame_done;
    logic [2:0]  status;
  } color_run_t;

  typedef struct {
    int itype, cmtype, cfirst, clen, ebits, pbits, w, h, idlen, desc;
    int cut;      // byte index that carries stream_end early, -1 for none
    int bad_pct;  // percent of palette indexes drawn from the whole 16-bit range
    bit ovf;      // end with an oversized packet header
    int extra;    // bytes appended after the image
    fill_t fill;
  } tga_spec_t;

  logic clk = 0;
  logic rst = 1;
  always #5 clk = ~clk;

  tga_in_if  in_ch();
  tga_out_if out_ch();

  tga_stream_decoder_unit uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  // Decoder model state.
  dec_phase_t  dec_phase;
  int unsigned dec_cnt, pleft, pcnt, ptot;
  logic [31:0] asm_word;
  bit          prun;
  logic [7:0]  hb[18];
  logic [31:0] palette[PalDepth];

  color_run_t expected_runs[$];
  byte unsigned file_bytes[$];
  int errors, checked, bytes_sent, files_sent, bad_status_seen;
  bit calm;
  longint cycles;

  function automatic int pix_bytes();
    return (int'(hb[16]) + 7) / 8;
  endfunction

  function automatic int ent_bytes();
    return (int'(hb[7]) + 7) / 8;
  endfunction

  function automatic int unsigned cmap_first();
    return {hb[4], hb[3]};
  endfunction

  function automatic int unsigned cmap_count();
    return {hb[6], hb[5]};
  endfunction

  function automatic logic [31:0] to_rgba(logic [31:0] w, int nb);
    if (nb == 4) return {w[31:24], w[7:0], w[15:8], w[23:16]};
    if (nb == 3) return {8'h00, w[7:0], w[15:8], w[23:16]};
    return {8'h00, 3'b000, w[4:0], 3'b000, w[9:5], 3'b000, w[14:10]};
  endfunction

  function automatic color_run_t make_run(logic [31:0] rgba, int unsigned run,
                                          int unsigned start, bit done, logic [2:0] st);
    color_run_t r;
    bit ha;
    ha = hb[2][0] ? (ent_bytes() == 4) : (pix_bytes() == 4);
    r.red = rgba[7:0];
    r.green = rgba[15:8];
    r.blue = rgba[23:16];
    r.alpha = ha ? rgba[31:24] : 8'h00;
    r.has_alpha = ha;
    r.run_length = run[7:0];
    r.first_pixel = start;
    r.top_origin = hb[17][5];
    r.frame_done = done;
    r.status = st;
    return r;
  endfunction

  function automatic void clear_frame();
    dec_phase = PH_HDR;
    dec_cnt = 0;
    foreach (hb[i]) hb[i] = 8'h00;
    asm_word = 0;
    pleft = 0;
    prun = 0;
    pcnt = 0;
    ptot = 0;
  endfunction

  function automatic bit abort(logic [2:0] st, output color_run_t r);
    dec_phase = PH_DONE;
    r = make_run(0, 0, pcnt, 1, st);
    return 1;
  endfunction

  function automatic logic [2:0] header_status();
    logic [7:0] t;
    t = hb[2];
    if ((t & ~8'h0B) != 0 || t[1:0] == 2'b11 || t[1:0] == 2'b00) return ST_FORMAT;
    if (t[0] && hb[1] == 0) return ST_NO_CMAP;
    if (t[0]) begin
      if (pix_bytes() < 1 || pix_bytes() > 2) return ST_FORMAT;
      if (ent_bytes() < 2 || ent_bytes() > 4) return ST_FORMAT;
    end else if (pix_bytes() < 2 || pix_bytes() > 4) begin
      return ST_FORMAT;
    end
    return ST_OK;
  endfunction

  function automatic bit start_pixels(output color_run_t r);
    pcnt = 0;
    dec_cnt = 0;
    asm_word = 0;
    pleft = 0;
    prun = 0;
    if (ptot == 0) begin
      dec_phase = PH_DONE;
      r = make_run(0, 0, 0, 1, ST_OK);
      return 1;
    end
    dec_phase = hb[2][3] ? PH_PKT : PH_PIX;
    return 0;
  endfunction

  function automatic bit after_id(output color_run_t r);
    if (hb[1] != 0) begin
      if (hb[2][0]) begin
        if (cmap_count() != 0) begin
          dec_phase = PH_CMAP_LOAD;
          dec_cnt = 0;
          pcnt = 0;
          asm_word = 0;
          return 0;
        end
      end else if (cmap_count() * ent_bytes() != 0) begin
        dec_phase = PH_CMAP_SKIP;
        dec_cnt = cmap_count() * ent_bytes();
        return 0;
      end
    end
    return start_pixels(r);
  endfunction

  function automatic bit close_pixel(output color_run_t r);
    logic [31:0] col;
    int unsigned idx, run, start;
    bit rle, done;
    rle = hb[2][3];
    if (hb[2][0]) begin
      idx = asm_word[15:0];
      if (idx < cmap_first() || idx - cmap_first() >= cmap_count() || idx >= PalDepth)
        return abort(ST_BAD_IDX, r);
      col = palette[idx];
    end else begin
      col = to_rgba(asm_word, pix_bytes());
    end
    run = (rle && prun) ? pleft : 1;
    start = pcnt;
    pcnt += run;
    done = (pcnt == ptot);
    dec_cnt = 0;
    asm_word = 0;
    if (rle) begin
      pleft = prun ? 0 : pleft - 1;
      if (pleft == 0) dec_phase = PH_PKT;
    end
    if (done) dec_phase = PH_DONE;
    r = make_run(col, run, start, done, ST_OK);
    return 1;
  endfunction

  // Advances the model by one accepted word; returns 1 when a result is due.
  function automatic bit decode_byte(logic [7:0] b, bit last, output color_run_t r);
    bit got;
    int unsigned cnt, slot;
    logic [2:0] st;
    got = 0;
    r = make_run(0, 0, 0, 0, ST_OK);
    case (dec_phase)
      PH_HDR: begin
        if (dec_cnt < 8 || (dec_cnt >= 12 && dec_cnt < 18)) hb[dec_cnt] = b;
        dec_cnt++;
        if (dec_cnt >= 18) begin
          dec_cnt = 0;
          st = header_status();
          if (st != ST_OK) begin
            got = abort(st, r);
          end else begin
            ptot = 32'({hb[13], hb[12]}) * 32'({hb[15], hb[14]});
            if (hb[0] != 0) begin
              dec_phase = PH_ID;
              dec_cnt = hb[0];
            end else begin
              got = after_id(r);
            end
          end
        end
      end
      PH_ID: begin
        dec_cnt--;
        if (dec_cnt == 0) got = after_id(r);
      end
      PH_CMAP_SKIP: begin
        dec_cnt--;
        if (dec_cnt == 0) got = start_pixels(r);
      end
      PH_CMAP_LOAD: begin
        asm_word |= 32'(b) << (8 * (dec_cnt & 3));
        dec_cnt++;
        if (dec_cnt >= ent_bytes()) begin
          slot = cmap_first() + pcnt;
          if (slot < PalDepth) palette[slot] = to_rgba(asm_word, ent_bytes());
          pcnt++;
          dec_cnt = 0;
          asm_word = 0;
          if (pcnt >= cmap_count()) got = start_pixels(r);
        end
      end
      PH_PKT: begin
        cnt = b[6:0] + 1;
        if (cnt > ptot - pcnt) begin
          got = abort(ST_OVERFLOW, r);
        end else begin
          pleft = cnt;
          prun = b[7];
          dec_cnt = 0;
          asm_word = 0;
          dec_phase = PH_PIX;
        end
      end
      PH_PIX: begin
        asm_word |= 32'(b) << (8 * (dec_cnt & 3));
        dec_cnt++;
        if (dec_cnt >= pix_bytes()) got = close_pixel(r);
      end
      default: ;
    endcase
    if (last) begin
      if (dec_phase != PH_DONE) begin
        if (got) begin
          r.frame_done = 1;
          r.status = ST_TRUNC;
        end else begin
          got = 1;
          r = make_run(0, 0, pcnt, 1, ST_TRUNC);
        end
      end
      clear_frame();
    end
    return got;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h, expected %0h (run %0d)", what, got, want, checked);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: random stall streaks, none while calm.
  int stall_left;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    color_run_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_runs.size() == 0) begin
        report("unexpected result", out_ch.status, 0);
      end else begin
        e = expected_runs.pop_front();
        if (out_ch.red !== e.red) report("red", out_ch.red, e.red);
        if (out_ch.green !== e.green) report("green", out_ch.green, e.green);
        if (out_ch.blue !== e.blue) report("blue", out_ch.blue, e.blue);
        if (out_ch.alpha !== e.alpha) report("alpha", out_ch.alpha, e.alpha);
        if (out_ch.has_alpha !== e.has_alpha) report("has_alpha", out_ch.has_alpha, e.has_alpha);
        if (out_ch.run_length !== e.run_length)
          report("run_length", out_ch.run_length, e.run_length);
        if (out_ch.first_pixel !== e.first_pixel)
          report("first_pixel", out_ch.first_pixel, e.first_pixel);
        if (out_ch.top_origin !== e.top_origin)
          report("top_origin", out_ch.top_origin, e.top_origin);
        if (out_ch.frame_done !== e.frame_done)
          report("frame_done", out_ch.frame_done, e.frame_done);
        if (out_ch.status !== e.status) report("status", out_ch.status, e.status);
        if (e.status != ST_OK) bad_status_seen++;
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, expected_runs.size());
      $display("tga_stream_decoder_unit test failed");
      $finish;
    end
  end

  task automatic send_word(byte unsigned b, bit last);
    color_run_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.stream_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_byte(b, last, r)) expected_runs.push_back(r);
    bytes_sent++;
  endtask

  function automatic byte unsigned fill_byte(fill_t f);
    if (f == FILL_ONES) return 8'hFF;
    if (f == FILL_ZEROS) return 8'h00;
    return $urandom_range(0, 255);
  endfunction

  function automatic void push_pixel(tga_spec_t s, int pb, int lo, int hi);
    int idx;
    if (s.itype[0]) begin
      if (lo <= hi && $urandom_range(0, 99) >= s.bad_pct) idx = $urandom_range(lo, hi);
      else idx = $urandom_range(0, 65535);
      file_bytes.push_back(idx[7:0]);
      if (pb > 1) file_bytes.push_back(idx[15:8]);
    end else begin
      repeat (pb) file_bytes.push_back(fill_byte(s.fill));
    end
  endfunction

  function automatic void build_file(tga_spec_t s);
    int pb, eb, rem, cnt, lo, hi;
    bit run;
    file_bytes.delete();
    file_bytes.push_back(s.idlen);
    file_bytes.push_back(s.cmtype);
    file_bytes.push_back(s.itype);
    file_bytes.push_back(s.cfirst[7:0]);
    file_bytes.push_back(s.cfirst[15:8]);
    file_bytes.push_back(s.clen[7:0]);
    file_bytes.push_back(s.clen[15:8]);
    file_bytes.push_back(s.ebits);
    repeat (4) file_bytes.push_back($urandom_range(0, 255));
    file_bytes.push_back(s.w[7:0]);
    file_bytes.push_back(s.w[15:8]);
    file_bytes.push_back(s.h[7:0]);
    file_bytes.push_back(s.h[15:8]);
    file_bytes.push_back(s.pbits);
    file_bytes.push_back(s.desc);
    repeat (s.idlen) file_bytes.push_back($urandom_range(0, 255));
    eb = (s.ebits + 7) / 8;
    if (s.cmtype != 0) repeat (s.clen * eb) file_bytes.push_back(fill_byte(s.fill));
    pb = (s.pbits + 7) / 8;
    if (pb < 1) pb = 1;
    if (pb > 4) pb = 4;
    lo = s.cfirst;
    hi = s.cfirst + s.clen - 1;
    if (hi > PalDepth - 1) hi = PalDepth - 1;
    rem = s.w * s.h;
    if (s.itype[3]) begin
      while (rem > 0) begin
        cnt = $urandom_range(1, rem < 128 ? rem : 128);
        run = $urandom_range(0, 1);
        file_bytes.push_back({run, 7'(cnt - 1)});
        if (run) push_pixel(s, pb, lo, hi);
        else repeat (cnt) push_pixel(s, pb, lo, hi);
        rem -= cnt;
      end
    end else begin
      repeat (rem) push_pixel(s, pb, lo, hi);
    end
    if (s.ovf && rem == 0) file_bytes.push_back(8'hFF);
    repeat (s.extra) file_bytes.push_back($urandom_range(0, 255));
    if (s.cut >= 0 && s.cut < file_bytes.size()) file_bytes = file_bytes[0:s.cut];
  endfunction

  task automatic send_file(tga_spec_t s);
    build_file(s);
    foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  function automatic tga_spec_t plain_spec(int itype, int pbits, int w, int h);
    tga_spec_t s;
    s.itype = itype;
    s.cmtype = 0;
    s.cfirst = 0;
    s.clen = 0;
    s.ebits = 0;
    s.pbits = pbits;
    s.w = w;
    s.h = h;
    s.idlen = 0;
    s.desc = 8'h20;
    s.cut = -1;
    s.bad_pct = 0;
    s.ovf = 0;
    s.extra = 0;
    s.fill = FILL_RANDOM;
    return s;
  endfunction

  function automatic tga_spec_t mapped_spec(int itype, int ebits, int pbits,
                                            int first, int len, int w, int h);
    tga_spec_t s;
    s = plain_spec(itype, pbits, w, h);
    s.cmtype = 1;
    s.cfirst = first;
    s.clen = len;
    s.ebits = ebits;
    return s;
  endfunction

  // Drops valid and waits until every expected result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_runs.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_truecolor();
    tga_spec_t s;
    s = plain_spec(2, 24, 2, 2);
    s.fill = FILL_ONES;
    send_file(s);
    s = plain_spec(2, 32, 3, 1);
    s.fill = FILL_ZEROS;
    s.desc = 8'h00;
    send_file(s);
    send_file(plain_spec(2, 16, 2, 2));
    s = plain_spec(10, 15, 130, 1);
    s.fill = FILL_ONES;
    send_file(s);
    send_file(plain_spec(10, 32, 3, 3));
  endtask

  task automatic test_colormapped();
    send_file(mapped_spec(1, 24, 8, 0, 16, 3, 2));
    send_file(mapped_spec(9, 32, 16, 250, 10, 4, 2));
    send_file(mapped_spec(9, 16, 8, 3, 256, 5, 1));
  endtask

  task automatic test_format_errors();
    tga_spec_t s;
    send_file(plain_spec(0, 24, 1, 1));
    send_file(plain_spec(3, 24, 1, 1));
    send_file(plain_spec(11, 24, 1, 1));
    send_file(plain_spec(2, 8, 1, 1));
    s = mapped_spec(1, 24, 8, 0, 4, 1, 1);
    s.cmtype = 0;
    send_file(s);
    send_file(mapped_spec(1, 8, 8, 0, 4, 1, 1));
  endtask

  task automatic test_special_cases();
    tga_spec_t s;
    send_file(plain_spec(2, 24, 0, 5));
    s = plain_spec(2, 24, 2, 1);
    s.cmtype = 1;
    s.clen = 3;
    s.ebits = 16;
    s.idlen = 255;
    send_file(s);
    s = mapped_spec(1, 24, 8, 10, 4, 4, 1);
    s.bad_pct = 100;
    send_file(s);
    s = plain_spec(10, 24, 3, 1);
    s.ovf = 1;
    send_file(s);
    s = plain_spec(2, 24, 4, 1);
    s.cut = 20;
    send_file(s);
    s = plain_spec(2, 16, 2, 1);
    s.extra = 3;
    send_file(s);
    // Pixel-completing word that also ends the stream early.
    s = plain_spec(2, 24, 2, 1);
    s.cut = 20;
    send_file(s);
    drain();
  endtask

  function automatic tga_spec_t random_spec();
    tga_spec_t s;
    int k;
    int tbits[4] = '{15, 16, 24, 32};
    k = $urandom_range(0, 99);
    if (k < 45) begin
      s = plain_spec($urandom_range(0, 1) ? 10 : 2, tbits[$urandom_range(0, 3)],
                     $urandom_range(0, 5), $urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) begin
        s.cmtype = $urandom_range(1, 255);
        s.clen = $urandom_range(0, 4);
        s.ebits = tbits[$urandom_range(0, 3)];
      end
    end else if (k < 85) begin
      s = mapped_spec($urandom_range(0, 1) ? 9 : 1, tbits[$urandom_range(0, 3)],
                      $urandom_range(0, 1) ? 8 : 16,
                      $urandom_range(0, 9) == 0 ? $urandom_range(240, 300) : $urandom_range(0, 60),
                      $urandom_range(1, 12), $urandom_range(0, 5), $urandom_range(0, 4));
      s.cmtype = $urandom_range(1, 255);
      s.bad_pct = $urandom_range(0, 3) == 0 ? 10 : 0;
    end else begin
      s = plain_spec($urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 3), $urandom_range(0, 3));
      s.cmtype = $urandom_range(0, 255);
      s.ebits = $urandom_range(0, 255);
      s.clen = $urandom_range(0, 3);
    end
    if ($urandom_range(0, 4) == 0) s.idlen = $urandom_range(1, 6);
    s.desc = $urandom_range(0, 255);
    if ($urandom_range(0, 11) == 0) s.ovf = 1;
    if ($urandom_range(0, 9) == 0) s.cut = $urandom_range(0, 40);
    if ($urandom_range(0, 7) == 0) s.extra = $urandom_range(1, 3);
    if ($urandom_range(0, 19) == 0) begin
      s.w = $urandom_range(100, 400);
      s.h = 1;
    end
    return s;
  endfunction

  task automatic test_random_files();
    bit held;
    held = 0;
    while (bytes_sent < 1900) begin
      calm = ($urandom_range(0, 7) == 0);
      send_file(random_spec());
      // Hold the input until the output side has caught up, once.
      if (!held) begin
        drain();
        held = 1;
      end
    end
    calm = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.stream_end = 1'b0;
    clear_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_truecolor();
    test_colormapped();
    test_format_errors();
    test_special_cases();
    test_random_files();
    in_ch.valid <= 1'b0;
    wait (expected_runs.size() == 0);
    repeat (20) @(posedge clk);
    $display("Streamed %0d files (%0d words); checked %0d colour runs, %0d with error status.",
             files_sent, bytes_sent, checked, bad_status_seen);
    if (errors == 0 && expected_runs.size() == 0) begin
      $display("tga_stream_decoder_unit test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_runs.size());
      $display("tga_stream_decoder_unit test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tga_sd_pkg.sv
rtl/tga_sd_if.sv
rtl/tga_sd_palette.sv
rtl/tga_sd_parser.sv
rtl/tga_sd_outbuf.sv
rtl/tga_stream_decoder_unit.sv
rtl/tga_sd_checker.sv
sim/tb_top.sv
